### rtl/ut2cal_pkg.sv
// Constants and helper function shared by the Unix time to calendar converter.
// No dependencies; the core module imports this package.
`default_nettype none

package ut2cal_pkg;

    // Accepted window: 2000-01-01T00:00:00Z up to, not including, 2100-01-01T00:00:00Z.
    localparam logic [31:0] FIRST_OK_TIME = 32'd946684800;
    localparam logic [31:0] END_OK_TIME   = 32'd4102444800;

    // Seconds per day is 128 * 675. The low seven bits pass straight through.
    localparam int          DAY_SHIFT      = 7;
    localparam logic [9:0]  DAY_REST       = 10'd675;
    localparam logic [30:0] RECIP_DAY_REST = 31'd1628906115;   // floor(2^40 / 675)

    // Day count of 1996-03-01, the start of a four-year cycle that runs
    // unbroken through the end of 2099.
    localparam logic [15:0] CYCLE_BASE_DAY = 16'd9556;
    localparam logic [10:0] CYCLE_DAYS     = 11'd1461;
    localparam logic [21:0] RECIP_CYCLE    = 22'd2939744;      // floor(2^32 / 1461)
    localparam logic [8:0]  YEAR_DAYS      = 9'd365;
    localparam logic [6:0]  BASE_YEAR_OFS  = 7'd4;             // 1996 lies four years before 2000

    // 1970-01-01 was a Thursday; shifting by three gives Monday as zero.
    localparam logic [15:0] WEEKDAY_SHIFT  = 16'd3;
    localparam logic [3:0]  WEEK_DAYS      = 4'd7;
    localparam logic [29:0] RECIP_WEEK     = 30'd613566756;    // floor(2^32 / 7)

    localparam logic [11:0] SEC_PER_HOUR   = 12'd3600;
    localparam logic [20:0] RECIP_HOUR     = 21'd1193046;      // floor(2^32 / 3600)
    localparam logic [6:0]  SEC_PER_MIN    = 7'd60;
    localparam logic [26:0] RECIP_MIN      = 27'd71582788;     // floor(2^32 / 60)

    // Month index in a year that starts on March 1; January and February are 10 and 11.
    localparam logic [3:0]  MONTH_JAN      = 4'd10;
    localparam logic [3:0]  MONTHS_IN_YEAR = 4'd12;

    // First day of each month within a March-based year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

### rtl/unix_time_to_calendar_core.sv
// Top level of the Unix time to calendar converter: a nine-stage pipeline.
// Depends on ut2cal_pkg for constants and the month start table.
`default_nettype none

// The converter takes a 32-bit Unix time in seconds and returns the UTC calendar
// date and time of day, along with the weekday (Monday is 1, Sunday is 7) and the
// year counted from 2000. Times before 2000-01-01 or from 2100-01-01 on give
// valid_res low and every other result field zero. The block is a nine-stage
// pipeline: a transfer on the input channel enters stage one, and its result
// reaches the output channel from stage nine, the output register. One transfer
// is accepted per clock cycle for as long as the output side is ready. All
// stages advance together; when a result waits at the output and out_ready is
// low, the whole pipeline holds and in_ready drops in the same cycle, so nothing
// is lost or repeated. Divisions by fixed numbers are done by reciprocal
// multiplication, then an estimate of quotient and remainder, then a single
// compare-and-subtract correction, each in its own stage. The date uses four-year
// cycles counted from 1996-03-01, which are exact over the whole accepted century.
module unix_time_to_calendar_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] unix_time,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             valid_res,
    output logic [4:0]       hours,
    output logic [5:0]       minutes,
    output logic [5:0]       secs,
    output logic [4:0]       day_of_month,
    output logic [3:0]       month_number,
    output logic [6:0]       year_offset,
    output logic [2:0]       weekday
);
    import ut2cal_pkg::*;

    // The pipeline advances whenever the output register is empty or being drained.
    logic adv;
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;

    logic [9:1] vld_reg;

    // Stage 1: range check and the reciprocal product for the day split.
    logic        s1_ok_reg,   s1_ok_next;
    logic [24:0] s1_x_reg,    s1_x_next;
    logic [6:0]  s1_lo_reg,   s1_lo_next;
    logic [55:0] s1_prod_reg, s1_prod_next;
    // Stage 2: estimated day count and remainder.
    logic        s2_ok_reg;
    logic [6:0]  s2_lo_reg;
    logic [15:0] s2_q_reg,    s2_q_next;
    logic [10:0] s2_rem_reg,  s2_rem_next;
    // Stage 3: exact day count and seconds of day.
    logic        s3_ok_reg;
    logic [15:0] s3_day_reg,  s3_day_next;
    logic [16:0] s3_sod_reg,  s3_sod_next;
    logic        s3_corr;
    // Stage 4: reciprocal products for cycle, weekday and hour.
    logic        s4_ok_reg;
    logic [15:0] s4_n_reg,    s4_n_next;
    logic [15:0] s4_w_reg,    s4_w_next;
    logic [16:0] s4_sod_reg;
    logic [37:0] s4_pn_reg,   s4_pn_next;
    logic [45:0] s4_pw_reg,   s4_pw_next;
    logic [37:0] s4_ph_reg,   s4_ph_next;
    // Stage 5: estimated quotients and remainders.
    logic        s5_ok_reg;
    logic [5:0]  s5_cyc_reg,  s5_cyc_next;
    logic [11:0] s5_k_reg,    s5_k_next;
    logic [3:0]  s5_r7_reg,   s5_r7_next;
    logic [5:0]  s5_h_reg,    s5_h_next;
    logic [12:0] s5_rh_reg,   s5_rh_next;
    logic [13:0] s5_w0;
    // Stage 6: corrected cycle, day in cycle, weekday, hour.
    logic        s6_ok_reg;
    logic [5:0]  s6_cyc_reg,  s6_cyc_next;
    logic [10:0] s6_k_reg,    s6_k_next;
    logic [2:0]  s6_wd_reg,   s6_wd_next;
    logic [4:0]  s6_hr_reg,   s6_hr_next;
    logic [11:0] s6_rh_reg,   s6_rh_next;
    logic        s6_kc, s6_hc;
    logic [3:0]  s6_r7;
    // Stage 7: year in cycle, day of year, minute product.
    logic        s7_ok_reg;
    logic [5:0]  s7_cyc_reg;
    logic [1:0]  s7_yic_reg,  s7_yic_next;
    logic [8:0]  s7_doy_reg,  s7_doy_next;
    logic [2:0]  s7_wd_reg;
    logic [4:0]  s7_hr_reg;
    logic [11:0] s7_rh_reg;
    logic [38:0] s7_pm_reg,   s7_pm_next;
    logic [10:0] s7_yr_days;
    // Stage 8: month index and estimated minutes.
    logic        s8_ok_reg;
    logic [5:0]  s8_cyc_reg;
    logic [1:0]  s8_yic_reg;
    logic [8:0]  s8_doy_reg;
    logic [3:0]  s8_mp_reg,   s8_mp_next;
    logic [2:0]  s8_wd_reg;
    logic [4:0]  s8_hr_reg;
    logic [6:0]  s8_m_reg,    s8_m_next;
    logic [6:0]  s8_rs_reg,   s8_rs_next;
    // Stage 9: output register.
    logic        valid_res_reg,    valid_res_next;
    logic [4:0]  hours_reg,        hours_next;
    logic [5:0]  minutes_reg,      minutes_next;
    logic [5:0]  secs_reg,         secs_next;
    logic [4:0]  day_reg,          day_next;
    logic [3:0]  month_reg,        month_next;
    logic [6:0]  year_reg,         year_next;
    logic [2:0]  weekday_reg,      weekday_next;
    logic        s9_mc, s9_janfeb;

    always_comb
    begin
        // Stage 1
        s1_ok_next   = (unix_time >= FIRST_OK_TIME) && (unix_time < END_OK_TIME);
        s1_x_next    = unix_time[31:DAY_SHIFT];
        s1_lo_next   = unix_time[DAY_SHIFT-1:0];
        s1_prod_next = 56'(s1_x_next) * 56'(RECIP_DAY_REST);

        // Stage 2: the estimate is exact or one short.
        s2_q_next    = s1_prod_reg[55:40];
        s2_rem_next  = 11'(26'(s1_x_reg) - 26'(s2_q_next) * 26'(DAY_REST));

        // Stage 3
        s3_corr      = s2_rem_reg >= 11'(DAY_REST);
        s3_day_next  = s2_q_reg + 16'(s3_corr);
        s3_sod_next  = {(s3_corr ? 10'(s2_rem_reg - 11'(DAY_REST)) : s2_rem_reg[9:0]),
                        s2_lo_reg};

        // Stage 4
        s4_n_next    = s3_day_reg - CYCLE_BASE_DAY;
        s4_w_next    = s3_day_reg + WEEKDAY_SHIFT;
        s4_pn_next   = 38'(s4_n_next) * 38'(RECIP_CYCLE);
        s4_pw_next   = 46'(s4_w_next) * 46'(RECIP_WEEK);
        s4_ph_next   = 38'(s3_sod_reg) * 38'(RECIP_HOUR);

        // Stage 5
        s5_cyc_next  = s4_pn_reg[37:32];
        s5_k_next    = 12'(17'(s4_n_reg) - 17'(s5_cyc_next) * 17'(CYCLE_DAYS));
        s5_w0        = s4_pw_reg[45:32];
        s5_r7_next   = 4'(s4_w_reg - 16'(s5_w0) * 16'(WEEK_DAYS));
        s5_h_next    = s4_ph_reg[37:32];
        s5_rh_next   = 13'(18'(s4_sod_reg) - 18'(s5_h_next) * 18'(SEC_PER_HOUR));

        // Stage 6
        s6_kc        = s5_k_reg >= 12'(CYCLE_DAYS);
        s6_cyc_next  = s5_cyc_reg + 6'(s6_kc);
        s6_k_next    = s6_kc ? 11'(s5_k_reg - 12'(CYCLE_DAYS)) : s5_k_reg[10:0];
        s6_r7        = (s5_r7_reg >= WEEK_DAYS) ? (s5_r7_reg - WEEK_DAYS) : s5_r7_reg;
        s6_wd_next   = 3'(s6_r7 + 4'd1);
        s6_hc        = s5_rh_reg >= 13'(SEC_PER_HOUR);
        s6_hr_next   = 5'(s5_h_reg + 6'(s6_hc));
        s6_rh_next   = s6_hc ? 12'(s5_rh_reg - 13'(SEC_PER_HOUR)) : s5_rh_reg[11:0];

        // Stage 7: the last day of a cycle stays in its fourth year.
        if (s6_k_reg < 11'(YEAR_DAYS))
        begin
            s7_yic_next = 2'd0;
        end
        else if (s6_k_reg < 11'(2 * YEAR_DAYS))
        begin
            s7_yic_next = 2'd1;
        end
        else if (s6_k_reg < 11'(3 * YEAR_DAYS))
        begin
            s7_yic_next = 2'd2;
        end
        else
        begin
            s7_yic_next = 2'd3;
        end
        s7_yr_days   = 11'(s7_yic_next) * 11'(YEAR_DAYS);
        s7_doy_next  = 9'(s6_k_reg - s7_yr_days);
        s7_pm_next   = 39'(s6_rh_reg) * 39'(RECIP_MIN);

        // Stage 8: count the month starts already passed.
        s8_mp_next   = 4'd0;
        for (int i = 1; i < int'(MONTHS_IN_YEAR); i++)
        begin
            if (s7_doy_reg >= month_start(4'(i)))
            begin
                s8_mp_next = s8_mp_next + 4'd1;
            end
        end
        s8_m_next    = s7_pm_reg[38:32];
        s8_rs_next   = 7'(13'(s7_rh_reg) - 13'(s8_m_next) * 13'(SEC_PER_MIN));

        // Stage 9
        s9_mc        = s8_rs_reg >= SEC_PER_MIN;
        s9_janfeb    = s8_mp_reg >= MONTH_JAN;
        valid_res_next = s8_ok_reg;
        hours_next     = '0;
        minutes_next   = '0;
        secs_next      = '0;
        day_next       = '0;
        month_next     = '0;
        year_next      = '0;
        weekday_next   = '0;
        if (s8_ok_reg)
        begin
            hours_next   = s8_hr_reg;
            minutes_next = 6'(s8_m_reg + 7'(s9_mc));
            secs_next    = 6'(s9_mc ? (s8_rs_reg - SEC_PER_MIN) : s8_rs_reg);
            day_next     = 5'(s8_doy_reg - month_start(s8_mp_reg) + 9'd1);
            month_next   = s9_janfeb ? (s8_mp_reg - 4'd9) : (s8_mp_reg + 4'd3);
            year_next    = 7'({s8_cyc_reg, 2'b00}) + 7'(s8_yic_reg) + 7'(s9_janfeb)
                           - BASE_YEAR_OFS;
            weekday_next = s8_wd_reg;
        end
    end

    // Valid bits travel with the data and are the only registers under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[8:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ok_reg   <= s1_ok_next;
            s1_x_reg    <= s1_x_next;
            s1_lo_reg   <= s1_lo_next;
            s1_prod_reg <= s1_prod_next;

            s2_ok_reg   <= s1_ok_reg;
            s2_lo_reg   <= s1_lo_reg;
            s2_q_reg    <= s2_q_next;
            s2_rem_reg  <= s2_rem_next;

            s3_ok_reg   <= s2_ok_reg;
            s3_day_reg  <= s3_day_next;
            s3_sod_reg  <= s3_sod_next;

            s4_ok_reg   <= s3_ok_reg;
            s4_n_reg    <= s4_n_next;
            s4_w_reg    <= s4_w_next;
            s4_sod_reg  <= s3_sod_reg;
            s4_pn_reg   <= s4_pn_next;
            s4_pw_reg   <= s4_pw_next;
            s4_ph_reg   <= s4_ph_next;

            s5_ok_reg   <= s4_ok_reg;
            s5_cyc_reg  <= s5_cyc_next;
            s5_k_reg    <= s5_k_next;
            s5_r7_reg   <= s5_r7_next;
            s5_h_reg    <= s5_h_next;
            s5_rh_reg   <= s5_rh_next;

            s6_ok_reg   <= s5_ok_reg;
            s6_cyc_reg  <= s6_cyc_next;
            s6_k_reg    <= s6_k_next;
            s6_wd_reg   <= s6_wd_next;
            s6_hr_reg   <= s6_hr_next;
            s6_rh_reg   <= s6_rh_next;

            s7_ok_reg   <= s6_ok_reg;
            s7_cyc_reg  <= s6_cyc_reg;
            s7_yic_reg  <= s7_yic_next;
            s7_doy_reg  <= s7_doy_next;
            s7_wd_reg   <= s6_wd_reg;
            s7_hr_reg   <= s6_hr_reg;
            s7_rh_reg   <= s6_rh_reg;
            s7_pm_reg   <= s7_pm_next;

            s8_ok_reg   <= s7_ok_reg;
            s8_cyc_reg  <= s7_cyc_reg;
            s8_yic_reg  <= s7_yic_reg;
            s8_doy_reg  <= s7_doy_reg;
            s8_mp_reg   <= s8_mp_next;
            s8_wd_reg   <= s7_wd_reg;
            s8_hr_reg   <= s7_hr_reg;
            s8_m_reg    <= s8_m_next;
            s8_rs_reg   <= s8_rs_next;

            valid_res_reg <= valid_res_next;
            hours_reg     <= hours_next;
            minutes_reg   <= minutes_next;
            secs_reg      <= secs_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            weekday_reg   <= weekday_next;
        end
    end

    assign out_valid    = vld_reg[9];
    assign valid_res    = valid_res_reg;
    assign hours        = hours_reg;
    assign minutes      = minutes_reg;
    assign secs         = secs_reg;
    assign day_of_month = day_reg;
    assign month_number = month_reg;
    assign year_offset  = year_reg;
    assign weekday      = weekday_reg;

`ifndef ASSERT_OFF
    // An accepted time inside the window always lands on a day count of this century.
    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && s3_ok_reg |-> s3_day_reg >= 16'd10957 && s3_day_reg <= 16'd47481)
        else $error("day count outside the accepted century");

    a_time_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> hours <= 5'd23 && minutes <= 6'd59 && secs <= 6'd59)
        else $error("time of day field out of range");

    a_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> month_number >= 4'd1 && month_number <= 4'd12 &&
        day_of_month >= 5'd1 && weekday >= 3'd1 && weekday <= 3'd7 &&
        year_offset <= 7'd99)
        else $error("calendar field out of range");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> hours == '0 && minutes == '0 && secs == '0 &&
        day_of_month == '0 && month_number == '0 && year_offset == '0 && weekday == '0)
        else $error("out-of-range time produced nonzero fields");

    // A stalled output must freeze the pipeline so the waiting result is not overwritten.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(year_offset) && $stable(secs))
        else $error("pending result changed during a stall");
`endif

endmodule

`default_nettype wire

### verif/tb_unix_time_to_calendar_core.sv
// Self-checking testbench for unix_time_to_calendar_core: directed edge dates, then random times.
// Needs only the converter RTL and package; expected dates are hand-typed or predicted here.
module tb_unix_time_to_calendar_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Window of accepted times and the day length, kept separate from the RTL package
    // so that the predictor does not lean on the design's own constants.
    localparam int unsigned OK_FROM     = 32'd946684800;   // 2000-01-01T00:00:00Z
    localparam int unsigned OK_UNTIL    = 32'd4102444800;  // 2100-01-01T00:00:00Z
    localparam int unsigned SEC_PER_DAY = 86400;
    localparam int unsigned DAY_2000    = 10957;           // day count of 2000-01-01
    localparam int unsigned HOLD_CYCLES = 60;              // long output hold-off

    // One converted result, laid out as the output ports of the block.
    typedef struct packed {
        logic       valid_res;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] secs;
        logic [4:0] day_of_month;
        logic [3:0] month_number;
        logic [6:0] year_offset;
        logic [2:0] weekday;
    } cal_result_t;

    // A result still owed by the block, with the time that caused it for the error log.
    typedef struct packed {
        logic [31:0] stamp;
        cal_result_t res;
    } date_expect_t;

    // One row of the directed table. Rows with known set carry a hand-typed result;
    // the others are checked against the predictor.
    typedef struct packed {
        logic [31:0] stamp;
        logic        known;
        cal_result_t res;
    } date_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [31:0] unix_time = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        valid_res;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  secs;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [6:0]  year_offset;
    logic [2:0]  weekday;

    date_expect_t pending_dates[$];
    date_row_t    edge_rows[$];
    date_expect_t oldest_date;
    int unsigned  mismatch_cnt  = 0;
    int unsigned  dates_checked = 0;
    int unsigned  in_window_cnt = 0;

    // Sender-to-receiver controls. Both are written with nonblocking assignments so that
    // the receiver sees a change at the following edge, whatever the process order.
    int unsigned  stall_pct     = 0;
    int unsigned  hold_req_cnt  = 0;
    int unsigned  hold_seen_cnt = 0;
    int unsigned  hold_left     = 0;
    int unsigned  idle_pct      = 0;

    unix_time_to_calendar_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .unix_time    (unix_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valid_res    (valid_res),
        .hours        (hours),
        .minutes      (minutes),
        .secs         (secs),
        .day_of_month (day_of_month),
        .month_number (month_number),
        .year_offset  (year_offset),
        .weekday      (weekday)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous fixed limit: the slowest correct run needs well under a tenth of this.
    initial
    begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

    // Predictor. The day count is turned into a date with the era-based
    // civil-from-days method on a calendar whose years start on March 1, so that
    // the leap day falls at the end of the year. Out-of-window times give all zeros.
    function automatic cal_result_t to_calendar(input logic [31:0] stamp);
        cal_result_t     r;
        longint unsigned sod, days, shifted, era, doe, yoe, doy, mp, yr, mo, dy;
        r = '0;
        if (stamp < OK_FROM || stamp >= OK_UNTIL)
            return r;
        sod     = stamp % SEC_PER_DAY;
        days    = stamp / SEC_PER_DAY;
        shifted = days + 719468;                 // day zero becomes 0000-03-01
        era     = shifted / 146097;
        doe     = shifted - era * 146097;
        yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp      = (5 * doy + 2) / 153;
        dy      = doy - (153 * mp + 2) / 5 + 1;
        mo      = (mp < 10) ? mp + 3 : mp - 9;
        yr      = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
        // The window check already rules out other years; this is only a guard.
        if (yr < 2000 || yr > 2099)
            return r;
        r.valid_res    = 1'b1;
        r.hours        = 5'(sod / 3600);
        r.minutes      = 6'((sod / 60) % 60);
        r.secs         = 6'(sod % 60);
        r.day_of_month = 5'(dy);
        r.month_number = 4'(mo);
        r.year_offset  = 7'(yr - 2000);
        // 1970-01-01 was a Thursday; adding three puts Monday at zero.
        r.weekday      = 3'((days + 3) % 7 + 1);
        return r;
    endfunction

    // Random times: mostly inside the window, with a good share on the window edges,
    // on midnight crossings, and around new year and the end of February.
    function automatic logic [31:0] pick_time();
        int unsigned yr, jan1, day, sod;
        logic [31:0] stamp;
        case ($urandom_range(9, 0))
            0: stamp = $urandom();
            1: stamp = ($urandom_range(1, 0) ? OK_UNTIL : OK_FROM) - 32'd4 + $urandom_range(7, 0);
            2, 3:
            begin
                day   = $urandom_range(OK_UNTIL / SEC_PER_DAY - 1, OK_FROM / SEC_PER_DAY);
                stamp = day * SEC_PER_DAY - 2 + $urandom_range(3, 0);
            end
            4:
            begin
                // Leap years before year yr of the century: 2000, 2004, ... (2100 is outside).
                yr   = $urandom_range(99, 0);
                jan1 = DAY_2000 + 365 * yr + (yr + 3) / 4;
                day  = $urandom_range(1, 0) ? jan1 - 1 : jan1 + 57 + $urandom_range(3, 0);
                case ($urandom_range(2, 0))
                    0:       sod = 0;
                    1:       sod = SEC_PER_DAY - 1;
                    default: sod = $urandom_range(SEC_PER_DAY - 1, 0);
                endcase
                stamp = day * SEC_PER_DAY + sod;
            end
            default: stamp = $urandom_range(OK_UNTIL - 1, OK_FROM);
        endcase
        return stamp;
    endfunction

    // Offers one time on the input channel and returns at the edge of its transfer.
    // After a transfer in_valid stays high unless an idle gap follows, so valid is
    // never lowered and raised in the same time step.
    task automatic send_time(input logic [31:0] stamp, input cal_result_t want);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99, 0) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        unix_time <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // The pipeline is several stages deep, so this result cannot leave in the
        // same cycle it was accepted; the monitor's pop at this edge is of an older one.
        pending_dates.push_back('{stamp, want});
    endtask

    // Drops valid and waits until every owed result has come back.
    task automatic drain_dates();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
    endtask

    task automatic run_phase(input int unsigned send_idle, input int unsigned recv_stall,
                             input int unsigned count);
        logic [31:0] stamp;
        idle_pct  = send_idle;
        stall_pct <= recv_stall;
        repeat (count)
        begin
            stamp = pick_time();
            send_time(stamp, to_calendar(stamp));
        end
        drain_dates();
    endtask

    function automatic void check_field(input string name, input logic [31:0] stamp,
                                        input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("unix_time %0d, %s: expected %0d, actual %0d", stamp, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // Directed table. The hand-typed rows are the ones that can be read off directly:
    // the two ends of the window, the well-known 2^31 - 1 instant, and times outside
    // the window, which must come back as all zeros with valid_res low.
    initial
    begin
        edge_rows.push_back('{32'd0,          1'b1, cal_result_t'('0)});
        edge_rows.push_back('{32'd946684799,  1'b1, cal_result_t'('0)});
        edge_rows.push_back('{32'd946684800,  1'b1,
                              '{1'b1, 5'd0, 6'd0, 6'd0, 5'd1, 4'd1, 7'd0, 3'd6}});
        edge_rows.push_back('{32'd951782399,  1'b0, cal_result_t'('0)});  // 2000-02-28 end
        edge_rows.push_back('{32'd951782400,  1'b0, cal_result_t'('0)});  // leap day 2000
        edge_rows.push_back('{32'd951868800,  1'b0, cal_result_t'('0)});  // 2000-03-01
        edge_rows.push_back('{32'd978307199,  1'b0, cal_result_t'('0)});  // 2000-12-31 end
        edge_rows.push_back('{32'd983404799,  1'b0, cal_result_t'('0)});  // 2001-02-28 end
        edge_rows.push_back('{32'd1078012800, 1'b0, cal_result_t'('0)});  // leap day 2004
        edge_rows.push_back('{32'd1431655765, 1'b0, cal_result_t'('0)});  // 0x55555555
        edge_rows.push_back('{32'd1700000000, 1'b0, cal_result_t'('0)});
        edge_rows.push_back('{32'd2147483647, 1'b1,
                              '{1'b1, 5'd3, 6'd14, 6'd7, 5'd19, 4'd1, 7'd38, 3'd2}});
        edge_rows.push_back('{32'd2147483648, 1'b0, cal_result_t'('0)});
        edge_rows.push_back('{32'd2863311530, 1'b0, cal_result_t'('0)});  // 0xAAAAAAAA
        edge_rows.push_back('{32'd4102358400, 1'b0, cal_result_t'('0)});  // 2099-12-31 start
        edge_rows.push_back('{32'd4102444799, 1'b1,
                              '{1'b1, 5'd23, 6'd59, 6'd59, 5'd31, 4'd12, 7'd99, 3'd4}});
        edge_rows.push_back('{32'd4102444800, 1'b1, cal_result_t'('0)});
        edge_rows.push_back('{32'hFFFFFFFF,   1'b1, cal_result_t'('0)});
    end

    // Output side. Each cycle out_ready is drawn against the current stall rate, except
    // during a hold-off, which this process counts down itself once the sender asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req_cnt != hold_seen_cnt)
            begin
                hold_seen_cnt = hold_req_cnt;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Result monitor: every output transfer is matched to the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("result with no input waiting for it: valid_res=%0d", valid_res);
                mismatch_cnt++;
            end
            else
            begin
                oldest_date = pending_dates.pop_front();
                check_field("valid_res",    oldest_date.stamp, oldest_date.res.valid_res,
                            valid_res);
                check_field("hours",        oldest_date.stamp, oldest_date.res.hours, hours);
                check_field("minutes",      oldest_date.stamp, oldest_date.res.minutes, minutes);
                check_field("secs",         oldest_date.stamp, oldest_date.res.secs, secs);
                check_field("day_of_month", oldest_date.stamp, oldest_date.res.day_of_month,
                            day_of_month);
                check_field("month_number", oldest_date.stamp, oldest_date.res.month_number,
                            month_number);
                check_field("year_offset",  oldest_date.stamp, oldest_date.res.year_offset,
                            year_offset);
                check_field("weekday",      oldest_date.stamp, oldest_date.res.weekday, weekday);
                dates_checked++;
                if (oldest_date.res.valid_res)
                    in_window_cnt++;
            end
        end
    end

    // Input side and run sequence.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows go in back to back with the output always ready.
        foreach (edge_rows[i])
            send_time(edge_rows[i].stamp,
                      edge_rows[i].known ? edge_rows[i].res : to_calendar(edge_rows[i].stamp));
        drain_dates();

        // Random times under different idle and stall mixes. Each phase ends with the
        // sender waiting until every owed result has arrived.
        run_phase(0, 0, 320);
        run_phase(88, 0, 200);
        run_phase(0, 88, 200);

        // Back pressure: the output holds off for a long stretch while the input keeps
        // offering a transfer every cycle, so the pipeline fills and in_ready falls.
        idle_pct     = 0;
        stall_pct    <= 0;
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (60)
        begin
            send_time(pick_time(), 'x);
            pending_dates[pending_dates.size() - 1].res =
                to_calendar(pending_dates[pending_dates.size() - 1].stamp);
        end
        drain_dates();

        run_phase(38, 38, 250);

        // Let any stray result surface before the verdict.
        repeat (20) @(posedge clk);
        $display("Converted %0d times: %0d inside 2000..2099, %0d outside the window.",
                 dates_checked, in_window_cnt, dates_checked - in_window_cnt);
        $display("Covered window ends, leap days, year ends, idle/stall mixes and a long hold-off.");
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/ut2cal_pkg.sv
rtl/unix_time_to_calendar_core.sv
verif/tb_unix_time_to_calendar_core.sv
